// ===== rtl/gauge_value_smoother_peak_hold_defines.svh =====
// assertion helpers for the top-level rtl
`ifndef GAUGE_VALUE_SMOOTHER_PEAK_HOLD_DEFINES_SVH
`define GAUGE_VALUE_SMOOTHER_PEAK_HOLD_DEFINES_SVH

// same-cycle implication, idle under reset
`define GVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle under reset
`define GVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gvs_pkg.sv =====
package gvs_pkg;

    localparam int VAL_W       = 24;
    localparam int TIME_W      = 32;
    localparam int FACTOR_W    = 17;
    localparam int RATE_W      = 23;
    localparam int HOLD_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int WHOLE_W     = 16;
    localparam int TENTHS_W    = 4;

    // gap magnitude and clamped step
    localparam int MAG_W       = VAL_W + 1;
    localparam int STEP_W      = MAG_W + 1;
    localparam int LIMIT_W     = MAG_W;
    localparam int SUM_W       = VAL_W + 3;
    localparam int SCALE_W     = MAG_W + FACTOR_W;
    localparam int FRAC_SHIFT  = 16;

    // rate limit: slew_rate * dt / 1000
    localparam int PROD_W      = RATE_W + TIME_W;
    localparam int DIV_LO      = 3;
    localparam int DIV_Y_W     = 32;
    localparam int DIV_MAGIC_W = 29;
    localparam int DIV_SHIFT   = 35;
    localparam int QPROD_W     = DIV_Y_W + DIV_MAGIC_W;
    localparam logic [DIV_MAGIC_W-1:0] DIV125_MAGIC = 29'h10624DD3;
    // beyond this product the limit can never bite
    localparam logic [PROD_W-1:0] RATE_SAT = PROD_W'(64'd1000 << LIMIT_W);

    localparam logic [TIME_W-1:0] FIRST_DT_MS = 32'd33;
    localparam logic [MAG_W-1:0]  SMALL_GAP   = 25'd13;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;

    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING   = 3'd0,
        REG_SLEW_RATE   = 3'd1,
        REG_HOLD_TIME   = 3'd2,
        REG_PEAK_ENABLE = 3'd3,
        REG_ZONE_ONE    = 3'd4,
        REG_ZONE_TWO    = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ZONE_LOW  = 2'd0,
        ZONE_MID  = 2'd1,
        ZONE_HIGH = 2'd2
    } t_zone;

    typedef struct packed {
        logic [FACTOR_W-1:0]     smoothing_factor;
        logic [RATE_W-1:0]       slew_rate;
        logic [HOLD_W-1:0]       hold_time_ms;
        logic                    peak_enable;
        logic signed [VAL_W-1:0] zone_one_limit;
        logic signed [VAL_W-1:0] zone_two_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [VAL_W-1:0] target;
        logic [TIME_W-1:0]       now_ms;
        logic                    snap;
        logic [LIMIT_W-1:0]      limit;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/gvs_front.sv =====
module gvs_front import gvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_target,
    input  logic [TIME_W-1:0]       i_now_ms,
    input  logic                    i_snap,
    input  logic                    i_pop,
    output logic                    o_push,
    output t_item                   o_item
);

    logic [Q_CNT_W-1:0]      r_credit, n_credit;
    logic                    w_accept;

    logic                    r_have_time;
    logic [TIME_W-1:0]       r_last_time;

    logic                    r_f1_valid;
    logic signed [VAL_W-1:0] r_f1_target;
    logic [TIME_W-1:0]       r_f1_now;
    logic                    r_f1_snap;
    logic [TIME_W-1:0]       r_f1_dt;

    logic                    r_f2_valid;
    logic signed [VAL_W-1:0] r_f2_target;
    logic [TIME_W-1:0]       r_f2_now;
    logic                    r_f2_snap;
    logic [PROD_W-1:0]       r_f2_prod;

    logic                    r_f3_valid;
    t_item                   r_f3_item;

    logic [TIME_W-1:0]       n_dt;
    logic [PROD_W-1:0]       n_prod;
    logic [QPROD_W-1:0]      n_qprod;
    logic [LIMIT_W-1:0]      n_limit;

    // one credit per transaction between input and the head of the queue
    assign o_stall  = (r_credit == Q_CNT_W'(Q_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        case ({w_accept, i_pop})
            2'b10:   n_credit = r_credit + 1'b1;
            2'b01:   n_credit = r_credit - 1'b1;
            default: n_credit = r_credit;
        endcase
    end

    assign n_dt   = r_have_time ? (i_now_ms - r_last_time) : FIRST_DT_MS;
    assign n_prod = PROD_W'(r_f1_dt) * PROD_W'(i_cfg.slew_rate);

    // divide by 8, then by 125 through the reciprocal
    assign n_qprod = QPROD_W'(r_f2_prod[DIV_LO +: DIV_Y_W]) * QPROD_W'(DIV125_MAGIC);

    always_comb begin
        if (r_f2_prod >= RATE_SAT) begin
            n_limit = '1;
        end else begin
            n_limit = n_qprod[DIV_SHIFT +: LIMIT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit    <= '0;
            r_have_time <= 1'b0;
            r_last_time <= '0;
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_f3_valid  <= 1'b0;
        end else begin
            r_credit   <= n_credit;
            r_f1_valid <= w_accept;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
            if (w_accept) begin
                r_have_time <= 1'b1;
                r_last_time <= i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_target <= i_target;
            r_f1_now    <= i_now_ms;
            r_f1_snap   <= i_snap;
            r_f1_dt     <= n_dt;
        end
        r_f2_target <= r_f1_target;
        r_f2_now    <= r_f1_now;
        r_f2_snap   <= r_f1_snap;
        r_f2_prod   <= n_prod;
        r_f3_item.target <= r_f2_target;
        r_f3_item.now_ms <= r_f2_now;
        r_f3_item.snap   <= r_f2_snap;
        r_f3_item.limit  <= n_limit;
    end

    assign o_push = r_f3_valid;
    assign o_item = r_f3_item;

endmodule

// ===== rtl/gvs_queue.sv =====
module gvs_queue import gvs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));

endmodule

// ===== rtl/gvs_back.sv =====
module gvs_back import gvs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_q_status                 i_q_status,
    input  t_item                     i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VAL_W-1:0]   o_shown_value,
    output logic [1:0]                o_zone,
    output logic signed [VAL_W-1:0]   o_peak_high,
    output logic signed [VAL_W-1:0]   o_peak_low,
    output logic signed [WHOLE_W-1:0] o_whole_part,
    output logic [TENTHS_W-1:0]       o_tenths_digit
);

    logic signed [VAL_W-1:0] r_displayed;
    logic signed [VAL_W-1:0] r_held_high;
    logic signed [VAL_W-1:0] r_held_low;
    logic [TIME_W-1:0]       r_high_time;
    logic                    r_state_valid;

    logic                      r_out_valid;
    logic signed [VAL_W-1:0]   r_out_shown;
    t_zone                     r_out_zone;
    logic signed [VAL_W-1:0]   r_out_high;
    logic signed [VAL_W-1:0]   r_out_low;
    logic signed [WHOLE_W-1:0] r_out_whole;
    logic [TENTHS_W-1:0]       r_out_tenths;

    logic                    w_out_ready;
    logic                    w_advance;

    logic signed [VAL_W-1:0] n_start;
    logic signed [MAG_W-1:0] n_gap;
    logic [MAG_W-1:0]        n_mag;
    logic [SCALE_W-1:0]      n_scaled;
    logic [STEP_W-1:0]       n_step;
    logic [STEP_W-1:0]       n_limit;
    logic [STEP_W-1:0]       n_step_clamped;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [VAL_W-1:0] n_displayed;

    logic signed [VAL_W-1:0] n_held_high;
    logic signed [VAL_W-1:0] n_held_low;
    logic [TIME_W-1:0]       n_high_time;
    logic [TIME_W-1:0]       n_since_high;

    t_zone                     n_zone;
    logic [VAL_W-1:0]          n_abs;
    logic [WHOLE_W-1:0]        n_whole_mag;
    logic signed [WHOLE_W-1:0] n_whole;
    logic [11:0]               n_tenths_prod;

    // the state registers double as the first back stage
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_advance   = r_state_valid && w_out_ready;
    assign o_pop       = !i_q_status.empty && (!r_state_valid || w_out_ready);

    // smoothing step, the combinational recurrence of the block on r_displayed
    always_comb begin
        n_start        = i_head.snap ? i_head.target : r_displayed;
        n_gap          = MAG_W'(i_head.target) - MAG_W'(n_start);
        n_mag          = n_gap[MAG_W-1] ? MAG_W'(-n_gap) : MAG_W'(n_gap);
        n_scaled       = SCALE_W'(n_mag) * SCALE_W'(i_cfg.smoothing_factor);
        n_step         = n_scaled[FRAC_SHIFT +: STEP_W];
        n_limit        = STEP_W'(i_head.limit);
        n_step_clamped = (n_step > n_limit) ? n_limit : n_step;
        if (n_gap[MAG_W-1]) begin
            n_sum = SUM_W'(n_start) - $signed(SUM_W'(n_step_clamped));
        end else begin
            n_sum = SUM_W'(n_start) + $signed(SUM_W'(n_step_clamped));
        end
        if (n_mag < SMALL_GAP) begin
            n_displayed = i_head.target;
        end else if (n_sum > SUM_W'(VAL_MAX)) begin
            n_displayed = VAL_MAX;
        end else if (n_sum < SUM_W'(VAL_MIN)) begin
            n_displayed = VAL_MIN;
        end else begin
            n_displayed = n_sum[VAL_W-1:0];
        end
    end

    always_comb begin
        n_held_high = r_held_high;
        n_held_low  = r_held_low;
        n_high_time = r_high_time;
        if (i_head.target > r_held_high) begin
            n_held_high = i_head.target;
            n_high_time = i_head.now_ms;
        end
        if (i_head.target < r_held_low) begin
            n_held_low = i_head.target;
        end
        n_since_high = i_head.now_ms - n_high_time;
        if (n_since_high > TIME_W'(i_cfg.hold_time_ms)) begin
            n_held_high = i_head.target;
            n_held_low  = i_head.target;
        end
    end

    // presentation of the settled value
    always_comb begin
        if (r_displayed < i_cfg.zone_one_limit) begin
            n_zone = ZONE_LOW;
        end else if (r_displayed < i_cfg.zone_two_limit) begin
            n_zone = ZONE_MID;
        end else begin
            n_zone = ZONE_HIGH;
        end
        n_abs         = r_displayed[VAL_W-1] ? VAL_W'(-r_displayed) : VAL_W'(r_displayed);
        n_whole_mag   = n_abs[VAL_W-1:8];
        n_whole       = r_displayed[VAL_W-1] ? $signed(-n_whole_mag) : $signed(n_whole_mag);
        n_tenths_prod = 12'(n_abs[7:0]) * 12'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_displayed   <= '0;
            r_held_high   <= VAL_MIN;
            r_held_low    <= VAL_MAX;
            r_high_time   <= '0;
            r_state_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_displayed <= n_displayed;
                if (i_cfg.peak_enable) begin
                    r_held_high <= n_held_high;
                    r_held_low  <= n_held_low;
                    r_high_time <= n_high_time;
                end
                r_state_valid <= 1'b1;
            end else if (w_advance) begin
                r_state_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_shown  <= r_displayed;
            r_out_zone   <= n_zone;
            r_out_high   <= r_held_high;
            r_out_low    <= r_held_low;
            r_out_whole  <= n_whole;
            r_out_tenths <= n_tenths_prod[11:8];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_shown_value  = r_out_shown;
    assign o_zone         = r_out_zone;
    assign o_peak_high    = r_out_high;
    assign o_peak_low     = r_out_low;
    assign o_whole_part   = r_out_whole;
    assign o_tenths_digit = r_out_tenths;

endmodule

// ===== rtl/gauge_value_smoother_peak_hold.sv =====
// Gauge smoother with peak hold. One transaction is taken per clock cycle,
// sustained while o_stall is low. A three-stage front works out the elapsed
// time and the rate limit (one multiply, then a reciprocal multiply for the
// divide by 1000); an eight-entry queue decouples it from the back, whose
// combinational multiply-clamp-add on the displayed value sets the
// throughput, followed by one output register. o_stall rises once eight
// transactions are held between the input and the back end. Configuration
// is written through i_cfg_we, i_cfg_index and i_cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
`include "gauge_value_smoother_peak_hold_defines.svh"

module gauge_value_smoother_peak_hold import gvs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VAL_W-1:0]   i_target,
    input  logic [TIME_W-1:0]         i_now_ms,
    input  logic                      i_snap,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VAL_W-1:0]   o_shown_value,
    output logic [1:0]                o_zone,
    output logic signed [VAL_W-1:0]   o_peak_high,
    output logic signed [VAL_W-1:0]   o_peak_low,
    output logic signed [WHOLE_W-1:0] o_whole_part,
    output logic [TENTHS_W-1:0]       o_tenths_digit
);

    t_cfg      r_cfg;
    logic      w_push;
    logic      w_pop;
    t_item     w_front_item;
    t_item     w_head;
    t_q_status w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_factor <= FACTOR_W'(13107);
            r_cfg.slew_rate        <= RATE_W'(25600);
            r_cfg.hold_time_ms     <= HOLD_W'(2000);
            r_cfg.peak_enable      <= 1'b0;
            r_cfg.zone_one_limit   <= '0;
            r_cfg.zone_two_limit   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SMOOTHING:   r_cfg.smoothing_factor <= i_cfg_data[FACTOR_W-1:0];
                REG_SLEW_RATE:   r_cfg.slew_rate        <= i_cfg_data[RATE_W-1:0];
                REG_HOLD_TIME:   r_cfg.hold_time_ms     <= i_cfg_data[HOLD_W-1:0];
                REG_PEAK_ENABLE: r_cfg.peak_enable      <= i_cfg_data[0];
                REG_ZONE_ONE:    r_cfg.zone_one_limit   <= $signed(i_cfg_data);
                REG_ZONE_TWO:    r_cfg.zone_two_limit   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    gvs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_target (i_target),
        .i_now_ms (i_now_ms),
        .i_snap   (i_snap),
        .i_pop    (w_pop),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    gvs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    gvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_status     (w_q_status),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_shown_value  (o_shown_value),
        .o_zone         (o_zone),
        .o_peak_high    (o_peak_high),
        .o_peak_low     (o_peak_low),
        .o_whole_part   (o_whole_part),
        .o_tenths_digit (o_tenths_digit)
    );

    // credits must keep the queue from overflowing
    `GVS_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_push, !w_q_status.full, "push into full queue")
    `GVS_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_status.empty, "pop from empty queue")
    // a full credit count means most transactions already sit in the queue
    `GVS_ASSERT_NOW(a_stall_has_work, i_clk, i_rst_n, o_stall, !w_q_status.empty, "stall with empty queue")

endmodule

// ===== dv/tb_gauge_value_smoother_peak_hold.sv =====
module tb_gauge_value_smoother_peak_hold;
    timeunit 1ns;
    timeprecision 1ps;
    import gvs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic signed [VAL_W-1:0]   shown;
        logic [1:0]                zone;
        logic signed [VAL_W-1:0]   peak_high;
        logic signed [VAL_W-1:0]   peak_low;
        logic signed [WHOLE_W-1:0] whole;
        logic [TENTHS_W-1:0]       tenths;
    } t_gauge_reading;

    class gauge_tracker;
        t_cfg                    cfg;
        logic signed [VAL_W-1:0] shown;
        logic signed [VAL_W-1:0] held_high;
        logic signed [VAL_W-1:0] held_low;
        logic [TIME_W-1:0]       last_ms;
        logic [TIME_W-1:0]       high_ms;
        bit                      have_time;
        t_gauge_reading          readings_due[$];
        int                      mismatches;
        int                      readings_seen;

        function new();
            cfg.smoothing_factor = 17'd13107;
            cfg.slew_rate        = 23'd25600;
            cfg.hold_time_ms     = 16'd2000;
            cfg.peak_enable      = 1'b0;
            cfg.zone_one_limit   = '0;
            cfg.zone_two_limit   = '0;
            shown      = '0;
            held_high  = VAL_MIN;
            held_low   = VAL_MAX;
            last_ms    = '0;
            high_ms    = '0;
            have_time  = 0;
            mismatches = 0;
            readings_seen = 0;
        endfunction

        function void take_setting(t_cfg c);
            cfg = c;
        endfunction

        function void note_sample(logic signed [VAL_W-1:0] tgt, logic [TIME_W-1:0] now_ms,
                                  logic snap);
            longint            gap;
            longint            mag;
            longint            lim;
            longint            next_val;
            longint            whole;
            longint            frac;
            logic [TIME_W-1:0] dt;
            logic [TIME_W-1:0] since_high;
            t_gauge_reading    r;
            if (snap)
                shown = tgt;
            gap = longint'(tgt) - longint'(shown);
            mag = (gap < 0) ? -gap : gap;
            if (mag < 13) begin
                shown = tgt;
            end else begin
                dt  = have_time ? now_ms - last_ms : FIRST_DT_MS;
                lim = (longint'(cfg.slew_rate) * longint'(dt)) / 1000;
                mag = (mag * longint'(cfg.smoothing_factor)) >>> 16;
                if (mag > lim)
                    mag = lim;
                next_val = longint'(shown) + ((gap < 0) ? -mag : mag);
                if (next_val > longint'(VAL_MAX))
                    next_val = longint'(VAL_MAX);
                if (next_val < longint'(VAL_MIN))
                    next_val = longint'(VAL_MIN);
                shown = next_val[VAL_W-1:0];
            end
            last_ms   = now_ms;
            have_time = 1;

            if (cfg.peak_enable) begin
                if (tgt > held_high) begin
                    held_high = tgt;
                    high_ms   = now_ms;
                end
                if (tgt < held_low)
                    held_low = tgt;
                since_high = now_ms - high_ms;
                if (since_high > TIME_W'(cfg.hold_time_ms)) begin
                    held_high = tgt;
                    held_low  = tgt;
                end
            end

            if (shown < cfg.zone_one_limit)
                r.zone = ZONE_LOW;
            else if (shown < cfg.zone_two_limit)
                r.zone = ZONE_MID;
            else
                r.zone = ZONE_HIGH;

            mag   = (shown < 0) ? -longint'(shown) : longint'(shown);
            whole = mag / 256;
            if (shown < 0)
                whole = -whole;
            frac  = mag % 256;

            r.shown     = shown;
            r.peak_high = held_high;
            r.peak_low  = held_low;
            r.whole     = whole[WHOLE_W-1:0];
            r.tenths    = TENTHS_W'((frac * 10) >> 8);
            readings_due.push_back(r);
        endfunction

        function void check_reading(t_gauge_reading got);
            t_gauge_reading want;
            readings_seen++;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reading with nothing due: shown %0d zone %0d", got.shown,
                             got.zone);
                return;
            end
            want = readings_due.pop_front();
            if (got.shown !== want.shown || got.zone !== want.zone
                    || got.peak_high !== want.peak_high || got.peak_low !== want.peak_low
                    || got.whole !== want.whole || got.tenths !== want.tenths) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reading %0d expected: shown %0d zone %0d high %0d low %0d whole %0d tenths %0d",
                             readings_seen, want.shown, want.zone, want.peak_high,
                             want.peak_low, want.whole, want.tenths);
                    $display("reading %0d actual:   shown %0d zone %0d high %0d low %0d whole %0d tenths %0d",
                             readings_seen, got.shown, got.zone, got.peak_high,
                             got.peak_low, got.whole, got.tenths);
                end
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [VAL_W-1:0]   i_target;
    logic [TIME_W-1:0]         i_now_ms;
    logic                      i_snap;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [VAL_W-1:0]   o_shown_value;
    logic [1:0]                o_zone;
    logic signed [VAL_W-1:0]   o_peak_high;
    logic signed [VAL_W-1:0]   o_peak_low;
    logic signed [WHOLE_W-1:0] o_whole_part;
    logic [TENTHS_W-1:0]       o_tenths_digit;

    gauge_tracker            tracker;
    bit                      quiet = 0;
    int                      cycles = 0;
    int                      samples_sent = 0;
    int                      settings_used = 0;
    logic signed [VAL_W-1:0] prev_target = '0;
    logic [TIME_W-1:0]       clock_ms = '0;

    gauge_value_smoother_peak_hold dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_target       (i_target),
        .i_now_ms       (i_now_ms),
        .i_snap         (i_snap),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_shown_value  (o_shown_value),
        .o_zone         (o_zone),
        .o_peak_high    (o_peak_high),
        .o_peak_low     (o_peak_low),
        .o_whole_part   (o_whole_part),
        .o_tenths_digit (o_tenths_digit)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_gauge_value_smoother_peak_hold failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_reading(t_gauge_reading'{o_shown_value, o_zone, o_peak_high,
                                                   o_peak_low, o_whole_part,
                                                   o_tenths_digit});
    end

    // receiver back-pressure: bursts, with calm stretches in between
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic push_sample(logic signed [VAL_W-1:0] tgt, logic [TIME_W-1:0] now_ms,
                               logic snap);
        i_valid  <= 1'b1;
        i_target <= tgt;
        i_now_ms <= now_ms;
        i_snap   <= snap;
        do @(posedge i_clk); while (o_stall);
        tracker.note_sample(tgt, now_ms, snap);
        samples_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.readings_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(t_cfg c);
        put_reg(REG_SMOOTHING, CFG_DATA_W'(c.smoothing_factor));
        put_reg(REG_SLEW_RATE, CFG_DATA_W'(c.slew_rate));
        put_reg(REG_HOLD_TIME, CFG_DATA_W'(c.hold_time_ms));
        put_reg(REG_PEAK_ENABLE, CFG_DATA_W'(c.peak_enable));
        put_reg(REG_ZONE_ONE, c.zone_one_limit);
        put_reg(REG_ZONE_TWO, c.zone_two_limit);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        tracker.take_setting(c);
        settings_used++;
    endtask

    function automatic t_cfg make_setting(int p);
        t_cfg                    c;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        a = VAL_W'($urandom);
        b = VAL_W'($urandom);
        c.smoothing_factor = FACTOR_W'($urandom_range(0, 65536));
        c.slew_rate        = RATE_W'($urandom_range(0, 200000));
        c.hold_time_ms     = HOLD_W'($urandom_range(0, 3000));
        c.peak_enable      = 1'b1;
        c.zone_one_limit   = (a < b) ? a : b;
        c.zone_two_limit   = (a < b) ? b : a;
        case (p)
            1: begin
                c.smoothing_factor = '0;
                c.slew_rate        = '1;
                c.hold_time_ms     = '0;
                c.peak_enable      = 1'b0;
                c.zone_one_limit   = VAL_MIN;
                c.zone_two_limit   = VAL_MAX;
            end
            2: begin
                c.smoothing_factor = FACTOR_W'(65536);
                c.slew_rate        = RATE_W'($urandom_range(0, 5000));
                c.hold_time_ms     = '1;
                c.zone_one_limit   = (a < b) ? b : a;
                c.zone_two_limit   = (a < b) ? a : b;
            end
            3: begin
                // factor above one lets the value overshoot
                c.smoothing_factor = FACTOR_W'($urandom_range(65537, 131071));
                c.slew_rate        = '1;
                c.zone_two_limit   = c.zone_one_limit;
            end
            4: begin
                c.slew_rate      = '0;
                c.peak_enable    = 1'b0;
                c.zone_one_limit = a;
                c.zone_two_limit = b;
            end
            5: begin
                c.smoothing_factor = FACTOR_W'(13107);
                c.slew_rate        = RATE_W'(25600);
                c.hold_time_ms     = HOLD_W'(2000);
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic run_phase(int count);
        logic signed [VAL_W-1:0] tgt;
        int                      pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                tgt = prev_target + VAL_W'(int'($urandom_range(0, 8192)) - 4096);
            else if (pick < 60)
                tgt = tracker.shown + VAL_W'(int'($urandom_range(0, 30)) - 15);
            else if (pick < 90)
                tgt = VAL_W'($urandom);
            else if (pick < 94)
                tgt = VAL_MAX;
            else if (pick < 98)
                tgt = VAL_MIN;
            else
                tgt = '0;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 120));
            else if (pick < 95)
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 70000));
            else
                clock_ms = $urandom;
            push_sample(tgt, clock_ms, $urandom_range(0, 9) == 0);
            prev_target = tgt;
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_target    <= '0;
        i_now_ms    <= '0;
        i_snap      <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_SMOOTHING;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: first sample uses the 33 ms default interval
        push_sample(24'sd1000, 32'd5, 1'b0);
        push_sample(24'sd1000, 32'd10, 1'b0);
        push_sample(VAL_MAX, 32'd20, 1'b1);
        push_sample(VAL_MIN, 32'd1020, 1'b0);
        push_sample(24'sd1, 32'd1030, 1'b1);
        // gap just under and just at the small-gap threshold
        push_sample(24'sd13, 32'd1040, 1'b0);
        push_sample(24'sd26, 32'd1050, 1'b0);
        // timestamp going back, then wrapping
        push_sample(24'sd0, 32'hFFFF_FFF0, 1'b0);
        push_sample(24'sd5000, 32'h0000_0010, 1'b0);
        settle();

        apply_setting(t_cfg'{smoothing_factor: '1, slew_rate: '1, hold_time_ms: '0,
                             peak_enable: 1'b1, zone_one_limit: -24'sd256,
                             zone_two_limit: 24'sd256});
        // full-scale gap with factor near two saturates
        push_sample(VAL_MIN, 32'd100, 1'b1);
        push_sample(VAL_MAX, 32'd200, 1'b0);
        push_sample(24'sd0, 32'd300, 1'b0);
        push_sample(24'sd500, 32'd300, 1'b0);
        // hold of zero expires one ms after the new high
        push_sample(-24'sd500, 32'd301, 1'b0);
        push_sample(24'sd100, 32'd301, 1'b0);
        settle();

        // zone limits reversed, rate limit of zero
        apply_setting(t_cfg'{smoothing_factor: FACTOR_W'(65536), slew_rate: '0,
                             hold_time_ms: '1, peak_enable: 1'b1,
                             zone_one_limit: 24'sd1000, zone_two_limit: -24'sd1000});
        push_sample(24'sd3000, 32'd400, 1'b0);
        push_sample(24'sd3000, 32'd400, 1'b1);
        push_sample(-24'sd3000, 32'd66000, 1'b0);
        push_sample(24'sd2000, 32'h7FFF_FFFF, 1'b0);
        push_sample(-24'sd2000, 32'h8000_0000, 1'b1);
        clock_ms    = 32'h8000_0000;
        prev_target = -24'sd2000;

        for (int p = 0; p < 6; p++) begin
            settle();
            if (p == 5)
                quiet = 1;
            apply_setting(make_setting(p));
            if (p == 1)
                clock_ms = 32'hFFFF_F000;
            run_phase(140);
        end
        settle();
        repeat (20) @(posedge i_clk);

        $display("%0d samples sent across %0d register settings", samples_sent, settings_used);
        $display("%0d readings checked, %0d mismatches, %0d still due", tracker.readings_seen,
                 tracker.mismatches, tracker.readings_due.size());
        if (tracker.mismatches == 0 && tracker.readings_due.size() == 0)
            $display("tb_gauge_value_smoother_peak_hold passed");
        else
            $display("tb_gauge_value_smoother_peak_hold failed");
        $finish;
    end

endmodule
